// ----- rtl/core/sest_pkg.sv -----
// Shared types and constants for the scan exemption station table.
// Used by the interfaces, controller, datapath and top level.
package sest_pkg;

	localparam logic [1:0] CMD_REGISTER   = 2'd0;
	localparam logic [1:0] CMD_UNREGISTER = 2'd1;
	localparam logic [1:0] CMD_EXEMPT_REQ = 2'd2;
	localparam logic [1:0] CMD_REPORT_INT = 2'd3;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_PRESENT   = 3'd3;
	localparam logic [2:0] ST_REFUSED   = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [47:0] station_addr;
		logic        supports_coex;
		logic        start_exempt;
		logic        start_intolerant;
		logic        is_legacy;
		logic        tx_ready;
	} cmd_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        frame_send;
		logic [47:0] frame_addr;
		logic        frame_grant;
		logic        note_incapable_joined;
		logic        note_incapable_all_gone;
		logic        intolerance_changed;
		logic        incapable_present;
		logic        ev_requested;
		logic        ev_granted;
		logic        ev_cancelled;
		logic        clear_first_scan_flag;
	} res_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture input word, clear scan results
		logic scan;    // examine current slot, advance index
		logic commit;  // apply update to table
		logic rescan;  // second walk after unregister (scanner / exempt search)
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic need_rescan;
	} dp_stat_t;

endpackage

// ----- rtl/core/sest_if.sv -----
// Valid/ready channel interface carrying one word of type T.
// Depends on sest_pkg for the word types.
interface sest_if #(parameter type T = sest_pkg::cmd_word_t) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/sest_ctrl.sv -----
// Controller: sequences load, slot walks, commit and result hand-off.
// Depends on sest_pkg.
module sest_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output sest_pkg::dp_cmd_t   cmd,
	input  sest_pkg::dp_stat_t  stat
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_RESCAN = 3'd2;
	localparam logic [2:0] S_COMMIT = 3'd3;
	localparam logic [2:0] S_OUT    = 3'd4;

	logic [2:0] state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (stat.need_rescan) begin
					state_d = S_RESCAN;
				end else begin
					cmd.commit = 1'b1;
					state_d = S_OUT;
				end
			end
			S_RESCAN: begin
				cmd.rescan = 1'b1;
				if (stat.scan_last) begin
					cmd.commit = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept and deliver overlap");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid) else $error("commit without result");
endmodule

// ----- rtl/core/sest_dp.sv -----
// Datapath: slot table, serial walk over slots, update and result word.
// Depends on sest_pkg.
module sest_dp #(
	parameter int SLOTS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sest_pkg::cmd_word_t  in_word,
	input  sest_pkg::dp_cmd_t    cmd,
	output sest_pkg::dp_stat_t   stat,
	output sest_pkg::res_word_t  res
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	logic [SLOTS-1:0] used_q, coex_q, exempt_q, intol_q, legacy_q;
	logic [47:0]      addr_mem [SLOTS];

	sest_pkg::cmd_word_t w_q;
	sest_pkg::res_word_t res_q;
	logic [IW-1:0] idx_q;
	logic [47:0]   rd_q;     // addr of slot idx_q-1 (registered read)
	logic          rd_ok_q;  // rd_q is valid for the slot before idx_q
	logic [IW-1:0] rd_idx_q;
	// first pass results
	logic          hit_q, free_q, excp_q, other_scan_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	// second pass results
	logic          scan_rem_q, ex_q, incap_rem_q;
	logic [IW-1:0] ex_idx_q;
	logic [47:0]   ex_addr_q;
	logic          pass2_q;

	// the compare works on the registered memory read of the previous slot
	logic drain;
	assign drain = rd_ok_q;
	assign stat.scan_last   = (idx_q == LAST) && !rd_ok_q ? 1'b0 : (rd_ok_q && rd_idx_q == LAST);
	assign stat.need_rescan = (w_q.cmd == sest_pkg::CMD_UNREGISTER) && hit_q && !pass2_q;

	logic walking;
	assign walking = cmd.scan || cmd.rescan;

	// last slot of the second walk lands in the same cycle as commit
	logic last_ok, last_scan, last_ex, last_incap;
	assign last_ok    = cmd.rescan && drain && used_q[rd_idx_q] && rd_idx_q != hit_idx_q;
	assign last_scan  = last_ok && coex_q[rd_idx_q] && !exempt_q[rd_idx_q];
	assign last_ex    = last_ok && coex_q[rd_idx_q] && exempt_q[rd_idx_q];
	assign last_incap = last_ok && (intol_q[rd_idx_q] || legacy_q[rd_idx_q]);

	function automatic logic rescan_scan();
		return scan_rem_q || last_scan;
	endfunction
	function automatic logic ex_fin();
		return ex_q || last_ex;
	endfunction
	function automatic logic [IW-1:0] ex_idx_fin();
		return ex_q ? ex_idx_q : rd_idx_q;
	endfunction

	always_ff @(posedge clk) begin
		if (walking) rd_q <= addr_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0; coex_q <= '0; exempt_q <= '0; intol_q <= '0; legacy_q <= '0;
			idx_q <= '0; rd_ok_q <= 1'b0; rd_idx_q <= '0;
			hit_q <= 1'b0; free_q <= 1'b0; excp_q <= 1'b0; other_scan_q <= 1'b0;
			hit_idx_q <= '0; free_idx_q <= '0;
			scan_rem_q <= 1'b0; ex_q <= 1'b0; incap_rem_q <= 1'b0;
			ex_idx_q <= '0; ex_addr_q <= '0; pass2_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0; rd_ok_q <= 1'b0;
				hit_q <= 1'b0; free_q <= 1'b0; excp_q <= 1'b0; other_scan_q <= 1'b0;
				scan_rem_q <= 1'b0; ex_q <= 1'b0; incap_rem_q <= 1'b0; pass2_q <= 1'b0;
			end
			if (walking) begin
				rd_ok_q  <= 1'b1;
				rd_idx_q <= idx_q;
				if (idx_q != LAST) idx_q <= idx_q + 1'b1;
			end
			if (cmd.scan && drain) begin
				if (!free_q && !used_q[rd_idx_q]) begin
					free_q <= 1'b1; free_idx_q <= rd_idx_q;
				end
				if (used_q[rd_idx_q] && rd_q == w_q.station_addr && !hit_q) begin
					hit_q <= 1'b1; hit_idx_q <= rd_idx_q;
				end
				if (used_q[rd_idx_q] && (intol_q[rd_idx_q] || legacy_q[rd_idx_q]))
					excp_q <= 1'b1;
				// non-exempt scanner other than the addressed station
				if (used_q[rd_idx_q] && coex_q[rd_idx_q] && !exempt_q[rd_idx_q]
					&& rd_q != w_q.station_addr)
					other_scan_q <= 1'b1;
				if (rd_idx_q == LAST) begin
					idx_q <= '0; rd_ok_q <= 1'b0;
				end
			end
			if (cmd.rescan) begin
				pass2_q <= 1'b1;
				if (drain && used_q[rd_idx_q] && rd_idx_q != hit_idx_q) begin
					if (coex_q[rd_idx_q] && !exempt_q[rd_idx_q]) scan_rem_q <= 1'b1;
					if (coex_q[rd_idx_q] && exempt_q[rd_idx_q] && !ex_q) begin
						ex_q <= 1'b1; ex_idx_q <= rd_idx_q; ex_addr_q <= rd_q;
					end
					if (intol_q[rd_idx_q] || legacy_q[rd_idx_q]) incap_rem_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				case (w_q.cmd)
					sest_pkg::CMD_REGISTER: begin
						if (!hit_q && free_q) begin
							used_q[free_idx_q]   <= 1'b1;
							coex_q[free_idx_q]   <= w_q.supports_coex;
							exempt_q[free_idx_q] <= w_q.start_exempt;
							intol_q[free_idx_q]  <= w_q.start_intolerant;
							legacy_q[free_idx_q] <= w_q.is_legacy;
						end
					end
					sest_pkg::CMD_UNREGISTER: begin
						if (hit_q) begin
							used_q[hit_idx_q] <= 1'b0; coex_q[hit_idx_q] <= 1'b0;
							exempt_q[hit_idx_q] <= 1'b0; intol_q[hit_idx_q] <= 1'b0;
							legacy_q[hit_idx_q] <= 1'b0;
							if (coex_q[hit_idx_q] && !rescan_scan() && ex_fin() && w_q.tx_ready)
								exempt_q[ex_idx_fin()] <= 1'b0;
						end
					end
					sest_pkg::CMD_EXEMPT_REQ: begin
						if (hit_q && other_scan_q && w_q.tx_ready) exempt_q[hit_idx_q] <= 1'b1;
					end
					sest_pkg::CMD_REPORT_INT: begin
						if (hit_q) intol_q[hit_idx_q] <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) w_q <= in_word;
		if (cmd.commit && w_q.cmd == sest_pkg::CMD_REGISTER && !hit_q && free_q)
			addr_mem[free_idx_q] <= w_q.station_addr;
		else if (cmd.commit && w_q.cmd == sest_pkg::CMD_UNREGISTER && hit_q)
			addr_mem[hit_idx_q] <= '0;
	end

	logic incap_rem, revoke_due;
	assign incap_rem  = incap_rem_q || last_incap;
	assign revoke_due = coex_q[hit_idx_q] && !rescan_scan() && ex_fin();

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q <= '0;
			case (w_q.cmd)
				sest_pkg::CMD_REGISTER: begin
					if (hit_q) res_q.status <= sest_pkg::ST_PRESENT;
					else if (!free_q) res_q.status <= sest_pkg::ST_FULL;
					else res_q.note_incapable_joined <= w_q.is_legacy || w_q.start_intolerant;
					res_q.incapable_present <= excp_q
						|| (!hit_q && free_q && (w_q.is_legacy || w_q.start_intolerant));
				end
				sest_pkg::CMD_UNREGISTER: begin
					if (!hit_q) begin
						res_q.status <= sest_pkg::ST_NOT_FOUND;
						res_q.incapable_present <= excp_q;
					end else begin
						if (revoke_due) begin
							if (w_q.tx_ready) begin
								res_q.frame_send <= 1'b1;
								res_q.frame_addr <= ex_q ? ex_addr_q : rd_q;
								res_q.ev_cancelled <= 1'b1;
								res_q.clear_first_scan_flag <= 1'b1;
							end else res_q.status <= sest_pkg::ST_REFUSED;
						end
						res_q.note_incapable_all_gone <=
							(intol_q[hit_idx_q] || legacy_q[hit_idx_q]) && !incap_rem;
						res_q.incapable_present <= incap_rem;
					end
				end
				sest_pkg::CMD_EXEMPT_REQ: begin
					res_q.ev_requested <= 1'b1;
					res_q.incapable_present <= excp_q;
					if (!hit_q) res_q.status <= sest_pkg::ST_NOT_FOUND;
					else if (other_scan_q) begin
						if (w_q.tx_ready) begin
							res_q.frame_send <= 1'b1;
							res_q.frame_addr <= w_q.station_addr;
							res_q.frame_grant <= 1'b1;
							res_q.ev_granted <= 1'b1;
						end else res_q.status <= sest_pkg::ST_REFUSED;
					end
				end
				sest_pkg::CMD_REPORT_INT: begin
					if (!hit_q) begin
						res_q.status <= sest_pkg::ST_NOT_FOUND;
						res_q.incapable_present <= excp_q;
					end else begin
						res_q.intolerance_changed <= !intol_q[hit_idx_q];
						res_q.incapable_present <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign res = res_q;

	a_hit_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && hit_q |-> used_q[hit_idx_q]) else $error("hit on free slot");
	a_free_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && free_q |-> !used_q[free_idx_q]) else $error("free slot used");
	a_grant_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !res_q.frame_grant || res_q.frame_send) else $error("grant w/o frame");
endmodule

// ----- rtl/core/scan_exemption_station_table_core.sv -----
// Channel   | dir | word                  | handshake
// cmd_in    | in  | sest_pkg::cmd_word_t  | valid/ready
// res_out   | out | sest_pkg::res_word_t  | valid/ready
// One command at a time: load, a walk over all slots, a second walk over all
// slots for a found unregister, then commit, with the walks set by the single-port
// slot address store.
// Reset clears all slot flags at once; addresses of free slots are never compared.
// A stalled result holds the block; no new word is taken until it is delivered.
module scan_exemption_station_table_core #(
	parameter int SLOTS = 32
) (
	input  logic clk,
	input  logic arst_n,
	sest_if.sink   cmd_in,
	sest_if.source res_out
);
	sest_pkg::dp_cmd_t  dcmd;
	sest_pkg::dp_stat_t dstat;

	sest_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cmd_in.valid), .in_ready(cmd_in.ready),
		.out_valid(res_out.valid), .out_ready(res_out.ready),
		.cmd(dcmd), .stat(dstat)
	);

	sest_dp #(.SLOTS(SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_word(cmd_in.data), .cmd(dcmd), .stat(dstat), .res(res_out.data)
	);
endmodule

// ----- test/tb.sv -----
// Testbench for scan_exemption_station_table_core: random and directed command words,
// checked against a behavioral model of the station table. Depends on sest_pkg and sest_if.
module tb;

	localparam int SLOTS = 32;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sest_if #(.T(sest_pkg::cmd_word_t)) cmd_ch (clk);
	sest_if #(.T(sest_pkg::res_word_t)) res_ch (clk);

	scan_exemption_station_table_core #(.SLOTS(SLOTS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_in(cmd_ch.sink),
		.res_out(res_ch.source)
	);

	always #2 clk = ~clk;

	// station table copy
	bit          tbl_used[SLOTS];
	bit [47:0]   tbl_addr[SLOTS];
	bit          tbl_coex[SLOTS];
	bit          tbl_exempt[SLOTS];
	bit          tbl_intol[SLOTS];
	bit          tbl_legacy[SLOTS];

	sest_pkg::res_word_t pending_res[$];
	int          err_count = 0;
	int          words_sent = 0;
	int          words_checked = 0;
	int          frames_seen = 0;
	bit [47:0]   addr_pool[8];

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
	end

	function automatic int find_station(bit [47:0] a);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_used[i] && tbl_addr[i] == a)
				return i;
		return -1;
	endfunction

	function automatic bit incapable_any();
		for (int i = 0; i < SLOTS; i++)
			if (tbl_used[i] && (tbl_intol[i] || tbl_legacy[i]))
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic int count_scanners(int skip);
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (i != skip && tbl_used[i] && tbl_coex[i] && !tbl_exempt[i])
				n++;
		return n;
	endfunction

	function automatic sest_pkg::res_word_t apply_command(sest_pkg::cmd_word_t w);
		sest_pkg::res_word_t r;
		int s, f, e;
		bit was_incap;
		r = '0;
		s = find_station(w.station_addr);
		case (w.cmd)
			sest_pkg::CMD_REGISTER: begin
				if (s >= 0) begin
					r.status = sest_pkg::ST_PRESENT;
				end else begin
					f = -1;
					for (int i = 0; i < SLOTS; i++)
						if (!tbl_used[i] && f < 0)
							f = i;
					if (f < 0) begin
						r.status = sest_pkg::ST_FULL;
					end else begin
						tbl_used[f] = 1'b1;
						tbl_addr[f] = w.station_addr;
						tbl_coex[f] = w.supports_coex;
						tbl_exempt[f] = w.start_exempt;
						tbl_intol[f] = w.start_intolerant;
						tbl_legacy[f] = w.is_legacy;
						r.note_incapable_joined = w.is_legacy | w.start_intolerant;
					end
				end
			end
			sest_pkg::CMD_UNREGISTER: begin
				if (s < 0) begin
					r.status = sest_pkg::ST_NOT_FOUND;
				end else begin
					was_incap = tbl_legacy[s] | tbl_intol[s];
					tbl_used[s] = 1'b0;
					if (tbl_coex[s] && count_scanners(-1) == 0) begin
						e = -1;
						for (int i = 0; i < SLOTS; i++)
							if (e < 0 && tbl_used[i] && tbl_coex[i] && tbl_exempt[i])
								e = i;
						if (e >= 0) begin
							if (w.tx_ready) begin
								r.frame_send = 1'b1;
								r.frame_addr = tbl_addr[e];
								tbl_exempt[e] = 1'b0;
								r.ev_cancelled = 1'b1;
								r.clear_first_scan_flag = 1'b1;
							end else begin
								r.status = sest_pkg::ST_REFUSED;
							end
						end
					end
					if (was_incap && !incapable_any())
						r.note_incapable_all_gone = 1'b1;
					tbl_addr[s] = '0;
					tbl_coex[s] = 1'b0;
					tbl_exempt[s] = 1'b0;
					tbl_intol[s] = 1'b0;
					tbl_legacy[s] = 1'b0;
				end
			end
			sest_pkg::CMD_EXEMPT_REQ: begin
				r.ev_requested = 1'b1;
				if (s < 0) begin
					r.status = sest_pkg::ST_NOT_FOUND;
				end else if (count_scanners(s) > 0) begin
					if (w.tx_ready) begin
						r.frame_send = 1'b1;
						r.frame_addr = w.station_addr;
						r.frame_grant = 1'b1;
						tbl_exempt[s] = 1'b1;
						r.ev_granted = 1'b1;
					end else begin
						r.status = sest_pkg::ST_REFUSED;
					end
				end
			end
			default: begin
				if (s < 0)
					r.status = sest_pkg::ST_NOT_FOUND;
				else if (!tbl_intol[s]) begin
					tbl_intol[s] = 1'b1;
					r.intolerance_changed = 1'b1;
				end
			end
		endcase
		r.incapable_present = incapable_any();
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		err_count++;
	endtask

	// send one word; bursts and gaps are chosen by the caller through gap
	task automatic send_word(sest_pkg::cmd_word_t w, int gap);
		sest_pkg::res_word_t r;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.data <= w;
		cmd_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		r = apply_command(w);
		pending_res.push_back(r);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic sest_pkg::cmd_word_t make_word(bit [1:0] c, bit [47:0] a, bit [3:0] fl,
		bit rdy);
		sest_pkg::cmd_word_t w;
		w.cmd = c;
		w.station_addr = a;
		{w.supports_coex, w.start_exempt, w.start_intolerant, w.is_legacy} = fl;
		w.tx_ready = rdy;
		return w;
	endfunction

	function automatic bit [47:0] rand_addr();
		return {16'($urandom_range(0, 65535)), $urandom()};
	endfunction

	// receiver stall pattern
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(negedge clk);
			phase++;
			if ((phase / 300) % 3 == 0)
				res_ch.ready <= 1'b1;
			else
				res_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// result checker
	initial begin
		sest_pkg::res_word_t got, want;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				if (pending_res.size() == 0) begin
					report_mismatch("unexpected word", 64'(got), 64'(0));
				end else begin
					want = pending_res.pop_front();
					words_checked++;
					if (got.frame_send) frames_seen++;
					if (got.status !== want.status)
						report_mismatch("status", 64'(got.status), 64'(want.status));
					if (got.frame_send !== want.frame_send)
						report_mismatch("frame_send", 64'(got.frame_send),
							64'(want.frame_send));
					if (got.frame_addr !== want.frame_addr)
						report_mismatch("frame_addr", 64'(got.frame_addr),
							64'(want.frame_addr));
					if (got.frame_grant !== want.frame_grant)
						report_mismatch("frame_grant", 64'(got.frame_grant),
							64'(want.frame_grant));
					if (got.note_incapable_joined !== want.note_incapable_joined)
						report_mismatch("note_incapable_joined",
							64'(got.note_incapable_joined), 64'(want.note_incapable_joined));
					if (got.note_incapable_all_gone !== want.note_incapable_all_gone)
						report_mismatch("note_incapable_all_gone",
							64'(got.note_incapable_all_gone),
							64'(want.note_incapable_all_gone));
					if (got.intolerance_changed !== want.intolerance_changed)
						report_mismatch("intolerance_changed",
							64'(got.intolerance_changed), 64'(want.intolerance_changed));
					if (got.incapable_present !== want.incapable_present)
						report_mismatch("incapable_present",
							64'(got.incapable_present), 64'(want.incapable_present));
					if (got.ev_requested !== want.ev_requested)
						report_mismatch("ev_requested", 64'(got.ev_requested),
							64'(want.ev_requested));
					if (got.ev_granted !== want.ev_granted)
						report_mismatch("ev_granted", 64'(got.ev_granted),
							64'(want.ev_granted));
					if (got.ev_cancelled !== want.ev_cancelled)
						report_mismatch("ev_cancelled", 64'(got.ev_cancelled),
							64'(want.ev_cancelled));
					if (got.clear_first_scan_flag !== want.clear_first_scan_flag)
						report_mismatch("clear_first_scan_flag",
							64'(got.clear_first_scan_flag), 64'(want.clear_first_scan_flag));
				end
			end
		end
	end

	// drop valid and hold until every expected result is back
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (pending_res.size() != 0) @(negedge clk);
	endtask

	task automatic test_directed();
		bit [47:0] a0, a1, a2;
		a0 = 48'h0;
		a1 = 48'hFFFF_FFFF_FFFF;
		a2 = 48'hA5A5_5A5A_0F0F;
		send_word(make_word(sest_pkg::CMD_UNREGISTER, a1, 4'hF, 1'b1), 0);   // not found
		send_word(make_word(sest_pkg::CMD_EXEMPT_REQ, a1, 4'h0, 1'b1), 0);
		send_word(make_word(sest_pkg::CMD_REPORT_INT, a0, 4'h0, 1'b1), 0);
		send_word(make_word(sest_pkg::CMD_REGISTER, a0, 4'b1000, 1'b0), 0);  // coex scanner
		send_word(make_word(sest_pkg::CMD_REGISTER, a1, 4'b1100, 1'b1), 1);  // coex exempt
		send_word(make_word(sest_pkg::CMD_REGISTER, a1, 4'b0011, 1'b1), 0);  // already present
		send_word(make_word(sest_pkg::CMD_REGISTER, a2, 4'b1011, 1'b1), 0);  // incapable joins
		send_word(make_word(sest_pkg::CMD_EXEMPT_REQ, a2, 4'h0, 1'b0), 0);   // refused
		send_word(make_word(sest_pkg::CMD_EXEMPT_REQ, a2, 4'h0, 1'b1), 0);   // granted
		send_word(make_word(sest_pkg::CMD_EXEMPT_REQ, a1, 4'h0, 1'b1), 0);   // re-grant
		send_word(make_word(sest_pkg::CMD_EXEMPT_REQ, a0, 4'h0, 1'b1), 0);   // no other scanner
		send_word(make_word(sest_pkg::CMD_REPORT_INT, a0, 4'h0, 1'b1), 2);
		send_word(make_word(sest_pkg::CMD_REPORT_INT, a0, 4'h0, 1'b1), 0);   // already set
		send_word(make_word(sest_pkg::CMD_UNREGISTER, a0, 4'h0, 1'b0), 0);   // revoke refused
		send_word(make_word(sest_pkg::CMD_UNREGISTER, a2, 4'h0, 1'b1), 0);   // revoke a1
		send_word(make_word(sest_pkg::CMD_UNREGISTER, a1, 4'h0, 1'b1), 0);   // last station leaves
		wait_drained();
		// fill the table, then overflow
		for (int i = 0; i < SLOTS; i++)
			send_word(make_word(sest_pkg::CMD_REGISTER, 48'h100 + i, 4'($urandom()), 1'b1), 0);
		send_word(make_word(sest_pkg::CMD_REGISTER, 48'h7, 4'h0, 1'b1), 0);  // full
		for (int i = 0; i < SLOTS; i++)
			send_word(make_word(sest_pkg::CMD_UNREGISTER, 48'h100 + i, 4'h0,
				1'($urandom())), 0);
		wait_drained();
	endtask

	task automatic test_random(int count);
		sest_pkg::cmd_word_t w;
		int burst, gap;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			gap = 0;
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			end
			burst--;
			w = sest_pkg::cmd_word_t'($bits(sest_pkg::cmd_word_t)'(
				{$urandom(), $urandom(), $urandom()}));
			// mostly reuse a small address pool so commands hit stations
			if ($urandom_range(0, 9) != 0)
				w.station_addr = addr_pool[$urandom_range(0, 7)];
			if ($urandom_range(0, 3) != 0)
				w.tx_ready = 1'b1;
			send_word(w, gap);
			if (n == count / 2) wait_drained();
		end
	endtask

	initial begin
		for (int i = 0; i < 6; i++)
			addr_pool[i] = rand_addr();
		addr_pool[6] = 48'h0;
		addr_pool[7] = 48'hFFFF_FFFF_FFFF;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1800);
		wait_drained();
		repeat (2 * SLOTS + 20) @(negedge clk);
		$display("covered %0d command words, %0d results checked, %0d frames emitted",
			words_sent, words_checked, frames_seen);
		if (err_count == 0 && pending_res.size() == 0)
			$display("** scan_exemption_station_table_core: PASSED **");
		else
			$display("** scan_exemption_station_table_core: FAILED **");
		$finish;
	end

	initial begin
		#4000000;
		$display("timeout with %0d words outstanding", pending_res.size());
		$display("** scan_exemption_station_table_core: FAILED **");
		$finish;
	end
endmodule
